// ----- hw/rtl/skstore_pkg.sv -----
package skstore_pkg;

    // default number of key slots
    localparam int SLOTS_DEFAULT = 100;

    // field widths fixed by the interface
    localparam int WORD_W  = 64;
    localparam int TAG_W   = 2 * WORD_W;
    localparam int KEY_W   = 4 * WORD_W;
    localparam int COUNT_W = 7;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TAKE   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_ACT,
        ST_DONE
    } t_state;

endpackage

// ----- hw/rtl/skipped_key_store.sv -----
// channel  | valid       | stall       | payload
// ---------+-------------+-------------+-----------------------------------------------
// input    | i_in_valid  | o_in_stall  | i_operation, i_key_prefix, i_message_number,
//          |             |             | i_key_word_0..3
// output   | o_out_valid | i_out_stall | o_success, o_found_word_0..3, o_occupied_count
//
// a transaction walks the tag memory slot by slot, one read per cycle, from acceptance until
// a match or the last slot; after reset the tag memory valid marks are swept clear, with
// the input stalled meanwhile; a held result does not block the next transaction from being
// accepted, but the following result waits until the output register is taken
module skipped_key_store #(
    parameter int SLOTS = skstore_pkg::SLOTS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_operation,
    input  logic [skstore_pkg::WORD_W-1:0]   i_key_prefix,
    input  logic [skstore_pkg::WORD_W-1:0]   i_message_number,
    input  logic [skstore_pkg::WORD_W-1:0]   i_key_word_0,
    input  logic [skstore_pkg::WORD_W-1:0]   i_key_word_1,
    input  logic [skstore_pkg::WORD_W-1:0]   i_key_word_2,
    input  logic [skstore_pkg::WORD_W-1:0]   i_key_word_3,

    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_success,
    output logic [skstore_pkg::WORD_W-1:0]   o_found_word_0,
    output logic [skstore_pkg::WORD_W-1:0]   o_found_word_1,
    output logic [skstore_pkg::WORD_W-1:0]   o_found_word_2,
    output logic [skstore_pkg::WORD_W-1:0]   o_found_word_3,
    output logic [skstore_pkg::COUNT_W-1:0]  o_occupied_count
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);
    localparam int WW = skstore_pkg::WORD_W;
    localparam int TW = skstore_pkg::TAG_W;
    localparam int KW = skstore_pkg::KEY_W;

    // tag memory: valid mark on top, then prefix, then message number
    logic [TW:0]            r_tag_mem [SLOTS];
    // key memory: word 3 in the top bits, word 0 in the bottom
    logic [KW-1:0]          r_key_mem [SLOTS];

    skstore_pkg::t_state    r_state, n_state;

    logic [IW-1:0]          r_idx;       // next slot to read (or clear)
    logic [IW-1:0]          r_chk_idx;   // slot whose tag sits in r_tag_q
    logic [IW-1:0]          r_hit_idx;
    logic                   r_pend;      // r_tag_q holds a fresh read
    logic                   r_rd_done;   // last slot already read
    logic                   r_hit;
    logic [CW-1:0]          r_count;

    // latched transaction
    logic                   r_op;
    logic [WW-1:0]          r_prefix;
    logic [WW-1:0]          r_number;
    logic [KW-1:0]          r_key;

    logic [TW:0]            r_tag_q;
    logic [KW-1:0]          r_key_q;

    logic                   r_out_vld;
    logic                   r_success;
    logic [KW-1:0]          r_found;
    logic [skstore_pkg::COUNT_W-1:0] r_occ;

    // control from the sequencer
    logic                   tag_we;
    logic [IW-1:0]          tag_wa;
    logic [TW:0]            tag_wd;
    logic                   tag_re;
    logic                   key_we;
    logic                   key_re;
    logic                   out_load;
    logic                   in_stall;

    logic                   in_acc;
    logic                   slot_match;
    logic                   scan_hit;
    logic                   scan_end;

    assign in_acc = i_in_valid && !in_stall;

    // shared compare: a free slot for insert, a valid equal tag for take
    always_comb begin
        if (r_op == skstore_pkg::OP_INSERT) begin
            slot_match = !r_tag_q[TW];
        end else begin
            slot_match = r_tag_q[TW] && (r_tag_q[TW-1:0] == {r_prefix, r_number});
        end
        scan_hit = r_pend && slot_match;
        scan_end = r_pend && !slot_match && (r_chk_idx == LAST);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            skstore_pkg::ST_CLEAR: begin
                if (r_idx == LAST) n_state = skstore_pkg::ST_IDLE;
            end
            skstore_pkg::ST_IDLE: begin
                if (in_acc) n_state = skstore_pkg::ST_SCAN;
            end
            skstore_pkg::ST_SCAN: begin
                if (scan_hit) begin
                    n_state = skstore_pkg::ST_ACT;
                end else if (scan_end) begin
                    n_state = skstore_pkg::ST_DONE;
                end
            end
            skstore_pkg::ST_ACT: begin
                n_state = skstore_pkg::ST_DONE;
            end
            skstore_pkg::ST_DONE: begin
                if (!(r_out_vld && i_out_stall)) n_state = skstore_pkg::ST_IDLE;
            end
            default: begin
                n_state = skstore_pkg::ST_CLEAR;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        tag_we   = 1'b0;
        tag_wa   = r_hit_idx;
        tag_wd   = {1'b0, r_prefix, r_number};
        tag_re   = 1'b0;
        key_we   = 1'b0;
        key_re   = 1'b0;
        out_load = 1'b0;
        in_stall = 1'b1;
        case (r_state)
            skstore_pkg::ST_CLEAR: begin
                tag_we = 1'b1;
                tag_wa = r_idx;
                tag_wd = '0;
            end
            skstore_pkg::ST_IDLE: begin
                in_stall = 1'b0;
            end
            skstore_pkg::ST_SCAN: begin
                tag_re = !r_rd_done;
            end
            skstore_pkg::ST_ACT: begin
                // insert sets the valid mark, take clears it
                tag_we = 1'b1;
                tag_wd = {(r_op == skstore_pkg::OP_INSERT), r_prefix, r_number};
                key_we = (r_op == skstore_pkg::OP_INSERT);
                key_re = (r_op == skstore_pkg::OP_TAKE);
            end
            skstore_pkg::ST_DONE: begin
                out_load = !(r_out_vld && i_out_stall);
            end
            default: begin
                in_stall = 1'b1;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= skstore_pkg::ST_CLEAR;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_rd_done <= 1'b0;
            r_hit     <= 1'b0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= tag_re && (n_state == skstore_pkg::ST_SCAN);

            if (r_state == skstore_pkg::ST_CLEAR) begin
                if (r_idx != LAST) r_idx <= r_idx + IW'(1);
            end else if (in_acc) begin
                r_idx     <= '0;
                r_rd_done <= 1'b0;
                r_hit     <= 1'b0;
            end else if (tag_re) begin
                if (r_idx == LAST) begin
                    r_rd_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + IW'(1);
                end
            end

            if (scan_hit && r_state == skstore_pkg::ST_SCAN) r_hit <= 1'b1;

            if (r_state == skstore_pkg::ST_ACT) begin
                if (r_op == skstore_pkg::OP_INSERT) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_count <= r_count - CW'(1);
                end
            end

            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op     <= i_operation;
            r_prefix <= i_key_prefix;
            r_number <= i_message_number;
            r_key    <= {i_key_word_3, i_key_word_2, i_key_word_1, i_key_word_0};
        end
        if (tag_re) r_chk_idx <= r_idx;
        if (scan_hit) r_hit_idx <= r_chk_idx;
        if (out_load) begin
            r_success <= r_hit;
            r_found   <= (r_hit && r_op == skstore_pkg::OP_TAKE) ? r_key_q : '0;
            r_occ     <= skstore_pkg::COUNT_W'(r_count);
        end
    end

    // tag memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (tag_we) r_tag_mem[tag_wa] <= tag_wd;
        if (tag_re) r_tag_q <= r_tag_mem[r_idx];
    end

    // key memory, written on insert, read on a take hit
    always_ff @(posedge i_clk) begin
        if (key_we) r_key_mem[r_hit_idx] <= r_key;
        if (key_re) r_key_q <= r_key_mem[r_hit_idx];
    end

    assign o_in_stall       = in_stall;
    assign o_out_valid      = r_out_vld;
    assign o_success        = r_success;
    assign o_found_word_0   = r_found[WW-1:0];
    assign o_found_word_1   = r_found[2*WW-1:WW];
    assign o_found_word_2   = r_found[3*WW-1:2*WW];
    assign o_found_word_3   = r_found[4*WW-1:3*WW];
    assign o_occupied_count = r_occ;

endmodule

// ----- hw/rtl/skstore_chk.sv -----
module skstore_chk (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             o_in_stall,
    input  logic                             i_operation,
    input  logic [skstore_pkg::WORD_W-1:0]   i_key_prefix,
    input  logic [skstore_pkg::WORD_W-1:0]   i_message_number,
    input  logic [skstore_pkg::WORD_W-1:0]   i_key_word_0,
    input  logic [skstore_pkg::WORD_W-1:0]   i_key_word_1,
    input  logic [skstore_pkg::WORD_W-1:0]   i_key_word_2,
    input  logic [skstore_pkg::WORD_W-1:0]   i_key_word_3,
    input  logic                             o_out_valid,
    input  logic                             i_out_stall,
    input  logic                             o_success,
    input  logic [skstore_pkg::WORD_W-1:0]   o_found_word_0,
    input  logic [skstore_pkg::WORD_W-1:0]   o_found_word_1,
    input  logic [skstore_pkg::WORD_W-1:0]   o_found_word_2,
    input  logic [skstore_pkg::WORD_W-1:0]   o_found_word_3,
    input  logic [skstore_pkg::COUNT_W-1:0]  o_occupied_count
);

    // held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_occupied_count))
        else $error("result dropped while stalled");

    // block goes busy once a transaction is taken
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction taken without a scan");

    // clearing sweep keeps the input stalled after reset
    a_clear_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input open straight after reset");

    // failed operations return an all-zero key
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_success |->
            (o_found_word_0 == '0) && (o_found_word_1 == '0) &&
            (o_found_word_2 == '0) && (o_found_word_3 == '0))
        else $error("key words on a failed transaction");

endmodule

bind skipped_key_store skstore_chk u_skstore_chk (.*);

// ----- sim/skipped_key_store_checker.sv -----
module skipped_key_store_checker
    import skstore_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_operation,
    input  logic [WORD_W-1:0]  i_key_prefix,
    input  logic [WORD_W-1:0]  i_message_number,
    input  logic [WORD_W-1:0]  i_key_word_0,
    input  logic [WORD_W-1:0]  i_key_word_1,
    input  logic [WORD_W-1:0]  i_key_word_2,
    input  logic [WORD_W-1:0]  i_key_word_3,

    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_success,
    input  logic [WORD_W-1:0]  i_found_word_0,
    input  logic [WORD_W-1:0]  i_found_word_1,
    input  logic [WORD_W-1:0]  i_found_word_2,
    input  logic [WORD_W-1:0]  i_found_word_3,
    input  logic [COUNT_W-1:0] i_occupied_count,

    output int                 o_mismatch_count,
    output int                 o_pending_count
);

    typedef struct packed {
        logic               success;
        logic [WORD_W-1:0]  word_0;
        logic [WORD_W-1:0]  word_1;
        logic [WORD_W-1:0]  word_2;
        logic [WORD_W-1:0]  word_3;
        logic [COUNT_W-1:0] count;
    } t_key_result;

    // shadow copy of the slot store
    logic                   slot_live [SLOTS];
    logic [WORD_W-1:0]      slot_pfx  [SLOTS];
    logic [WORD_W-1:0]      slot_num  [SLOTS];
    logic [3:0][WORD_W-1:0] slot_key  [SLOTS];
    int unsigned            live_total;

    t_key_result            awaited_results [$];
    int                     mismatches = 0;

    function automatic t_key_result store_or_take(
        input logic                   op,
        input logic [WORD_W-1:0]      pfx,
        input logic [WORD_W-1:0]      num,
        input logic [3:0][WORD_W-1:0] key
    );
        t_key_result res;
        logic        done;
        res  = '0;
        done = 1'b0;
        if (op == OP_INSERT) begin
            // lowest free slot, no duplicate check
            for (int s = 0; s < SLOTS; s++) begin
                if (!done && !slot_live[s]) begin
                    slot_live[s] = 1'b1;
                    slot_pfx[s]  = pfx;
                    slot_num[s]  = num;
                    slot_key[s]  = key;
                    live_total++;
                    done = 1'b1;
                end
            end
        end else begin
            // first live slot with both tag halves equal
            for (int s = 0; s < SLOTS; s++) begin
                if (!done && slot_live[s] && slot_pfx[s] == pfx && slot_num[s] == num) begin
                    res.word_0   = slot_key[s][0];
                    res.word_1   = slot_key[s][1];
                    res.word_2   = slot_key[s][2];
                    res.word_3   = slot_key[s][3];
                    slot_live[s] = 1'b0;
                    if (live_total > 0)
                        live_total--;
                    done = 1'b1;
                end
            end
        end
        res.success = done;
        res.count   = COUNT_W'(live_total);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_key_result got;
        t_key_result want;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++)
                slot_live[s] = 1'b0;
            live_total = 0;
            awaited_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_success, i_found_word_0, i_found_word_1, i_found_word_2,
                        i_found_word_3, i_occupied_count};
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing outstanding: success %0b count %0d",
                                 $time, got.success, got.count);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.success !== want.success || got.word_0 !== want.word_0 ||
                        got.word_1 !== want.word_1 || got.word_2 !== want.word_2 ||
                        got.word_3 !== want.word_3 || got.count !== want.count) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch, want success %0b words %h %h %h %h count %0d",
                                     $time, want.success, want.word_0, want.word_1,
                                     want.word_2, want.word_3, want.count);
                            $display("%0t: mismatch, got  success %0b words %h %h %h %h count %0d",
                                     $time, got.success, got.word_0, got.word_1,
                                     got.word_2, got.word_3, got.count);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                awaited_results.push_back(store_or_take(i_operation, i_key_prefix,
                    i_message_number,
                    {i_key_word_3, i_key_word_2, i_key_word_1, i_key_word_0}));
        end
        o_mismatch_count <= mismatches;
        o_pending_count  <= awaited_results.size();
    end

endmodule

// ----- sim/skipped_key_store_test.sv -----
module skipped_key_store_test;
    import skstore_pkg::*;

    localparam int SLOTS      = SLOTS_DEFAULT;
    // longest legal quiet spell: clearing sweep, a full scan, long random gaps
    localparam int IDLE_LIMIT = 20 * SLOTS + 2000;
    localparam int TAG_POOL   = 12;
    localparam int SECTIONS   = 8;
    localparam int PER_SECT   = 86;

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_in_valid       = 1'b0;
    logic               o_in_stall;
    logic               i_operation      = OP_INSERT;
    logic [WORD_W-1:0]  i_key_prefix     = '0;
    logic [WORD_W-1:0]  i_message_number = '0;
    logic [WORD_W-1:0]  i_key_word_0     = '0;
    logic [WORD_W-1:0]  i_key_word_1     = '0;
    logic [WORD_W-1:0]  i_key_word_2     = '0;
    logic [WORD_W-1:0]  i_key_word_3     = '0;
    logic               o_out_valid;
    logic               i_out_stall      = 1'b0;
    logic               o_success;
    logic [WORD_W-1:0]  o_found_word_0;
    logic [WORD_W-1:0]  o_found_word_1;
    logic [WORD_W-1:0]  o_found_word_2;
    logic [WORD_W-1:0]  o_found_word_3;
    logic [COUNT_W-1:0] o_occupied_count;

    int mismatch_count;
    int pending_count;

    // idling percentages, changed per section
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    // small set of tags so that takes hit and duplicates pile up
    logic [WORD_W-1:0] pool_prefix [TAG_POOL];
    logic [WORD_W-1:0] pool_number [TAG_POOL];

    skipped_key_store #(.SLOTS(SLOTS)) u_top (.*);

    skipped_key_store_checker #(.SLOTS(SLOTS)) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_key_prefix     (i_key_prefix),
        .i_message_number (i_message_number),
        .i_key_word_0     (i_key_word_0),
        .i_key_word_1     (i_key_word_1),
        .i_key_word_2     (i_key_word_2),
        .i_key_word_3     (i_key_word_3),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_success        (o_success),
        .i_found_word_0   (o_found_word_0),
        .i_found_word_1   (o_found_word_1),
        .i_found_word_2   (o_found_word_2),
        .i_found_word_3   (o_found_word_3),
        .i_occupied_count (o_occupied_count),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // result side back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog: a stretch with no transaction on either channel ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // present one transaction, hold it until taken, then maybe idle a while
    task automatic send_item(
        input logic              op,
        input logic [WORD_W-1:0] pfx,
        input logic [WORD_W-1:0] num,
        input logic [WORD_W-1:0] k0,
        input logic [WORD_W-1:0] k1,
        input logic [WORD_W-1:0] k2,
        input logic [WORD_W-1:0] k3
    );
        i_in_valid       <= 1'b1;
        i_operation      <= op;
        i_key_prefix     <= pfx;
        i_message_number <= num;
        i_key_word_0     <= k0;
        i_key_word_1     <= k1;
        i_key_word_2     <= k2;
        i_key_word_3     <= k3;
        do
            @(posedge i_clk);
        while (!(i_in_valid && !o_in_stall));
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // mostly pool tags; some near misses on one half of the tag, a few fresh tags
    task automatic send_random(input int insert_pct);
        logic              op;
        logic [WORD_W-1:0] pfx;
        logic [WORD_W-1:0] num;
        int                pick;
        int                sel;
        op   = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_TAKE;
        pick = $urandom_range(TAG_POOL - 1);
        pfx  = pool_prefix[pick];
        num  = pool_number[pick];
        sel  = $urandom_range(99);
        if (sel < 6) begin
            pfx = rand_word();
        end else if (sel < 12) begin
            num = rand_word();
        end else if (sel < 16) begin
            pfx = rand_word();
            num = rand_word();
        end
        send_item(op, pfx, num, rand_word(), rand_word(), rand_word(), rand_word());
    endtask

    // wait with the input quiet until every outstanding result has been taken
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic [WORD_W-1:0] ones;
        logic [WORD_W-1:0] fives;
        logic [WORD_W-1:0] tens;
        int                mode;
        ones  = '1;
        fives = {(WORD_W/4){4'h5}};
        tens  = {(WORD_W/4){4'hA}};

        pool_prefix[0] = '0;
        pool_number[0] = ones;
        for (int p = 1; p < TAG_POOL; p++) begin
            pool_prefix[p] = rand_word();
            pool_number[p] = rand_word();
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: held through the clearing sweep, then the corner cases
        send_item(OP_TAKE,   '0,    '0,    ones,  ones,  ones,  ones);  // take from empty store
        send_item(OP_INSERT, '0,    '0,    ones,  ones,  ones,  ones);
        send_item(OP_INSERT, ones,  ones,  '0,    '0,    '0,    '0);
        send_item(OP_INSERT, '0,    '0,    fives, tens,  fives, tens);  // duplicate tag
        send_item(OP_INSERT, ones,  '0,    tens,  fives, tens,  fives);
        send_item(OP_TAKE,   ones,  64'd1, '0,    '0,    '0,    '0);    // prefix alone matches
        send_item(OP_TAKE,   '0,    ones,  '0,    '0,    '0,    '0);    // halves from two tags
        send_item(OP_TAKE,   '0,    '0,    '0,    '0,    '0,    '0);    // lowest duplicate first
        send_item(OP_INSERT, fives, tens,  tens,  tens,  fives, fives); // refills the freed slot
        send_item(OP_TAKE,   '0,    '0,    ones,  ones,  ones,  ones);
        send_item(OP_TAKE,   '0,    '0,    ones,  ones,  ones,  ones);  // both copies gone
        send_item(OP_TAKE,   ones,  ones,  ones,  ones,  ones,  ones);
        send_item(OP_TAKE,   ones,  '0,    '0,    '0,    '0,    '0);
        send_item(OP_TAKE,   fives, tens,  '0,    '0,    '0,    '0);
        send_item(OP_TAKE,   fives, tens,  '0,    '0,    '0,    '0);    // miss on empty again

        // random sections: fill towards a full store, then drain, twice over,
        // each under its own idling mix; the store is quiet between sections
        for (int sect = 0; sect < SECTIONS; sect++) begin
            drain_results();
            mode = (sect + sect / 4) % 4;
            case (mode)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 79;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 79;
                end
                default: begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                end
            endcase
            for (int n = 0; n < PER_SECT; n++)
                send_random((sect % 4 < 2) ? 90 : 20);
        end

        // end of stimulus: let every result come home, then a short quiet tail
        drain_results();
        repeat (2 * SLOTS + 20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
